### rtl/spms_pkg.sv
package spms_pkg;

   localparam int OP_W     = 2;
   localparam int SID_IN_W = 2;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_EXEC
   } state_type;

   // controller -> datapath strobes
   typedef struct packed {
      logic capture;
      logic fetch;
      logic commit;
   } ctrl_cmd_type;

endpackage

### rtl/spms_if.sv
interface spms_req_if;
   logic                                valid;
   logic                                ready;
   logic [spms_pkg::OP_W-1:0]           op;
   logic [spms_pkg::SID_IN_W-1:0]       stack_id;
   logic signed [spms_pkg::DATA_W-1:0]  push_value;

   modport source (output valid, op, stack_id, push_value, input ready);
   modport sink   (input valid, op, stack_id, push_value, output ready);
endinterface

interface spms_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [spms_pkg::DATA_W-1:0]  read_value;
   logic [spms_pkg::STATUS_W-1:0]       status;
   logic                                stack_empty;

   modport source (output valid, read_value, status, stack_empty, input ready);
   modport sink   (input valid, read_value, status, stack_empty, output ready);
endinterface

### rtl/spms_ctrl.sv
module spms_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output spms_pkg::ctrl_cmd_type cmd
);

   spms_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spms_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         spms_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = spms_pkg::S_FETCH;
            end
         end
         spms_pkg::S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = spms_pkg::S_EXEC;
         end
         spms_pkg::S_EXEC: begin
            // commit only once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = spms_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = spms_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/spms_dpath.sv
module spms_dpath #(
   parameter int POOL_SLOTS  = 16,
   parameter int STACK_COUNT = 3
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  spms_pkg::ctrl_cmd_type                cmd,
   input  logic [spms_pkg::OP_W-1:0]             req_op,
   input  logic [spms_pkg::SID_IN_W-1:0]         req_stack_id,
   input  logic signed [spms_pkg::DATA_W-1:0]    req_push_value,
   output logic signed [spms_pkg::DATA_W-1:0]    rsp_read_value,
   output logic [spms_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                  rsp_stack_empty
);

   localparam int IDX_W = $clog2(POOL_SLOTS);
   localparam int PTR_W = $clog2(POOL_SLOTS + 1);
   localparam int SID_W = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
   localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_SLOTS);

   // slot and stack-top stores
   logic [spms_pkg::DATA_W-1:0] value_mem [POOL_SLOTS];
   logic [PTR_W-1:0]            link_mem  [POOL_SLOTS];
   logic [PTR_W-1:0]            top_mem   [STACK_COUNT];
   logic [STACK_COUNT-1:0]      top_vld_ff;

   logic [PTR_W-1:0] free_head_ff, free_head_in;
   logic [PTR_W-1:0] fresh_ff, fresh_in;   // slots >= fresh never written

   // captured request
   logic [spms_pkg::OP_W-1:0]   op_ff;
   logic [SID_W-1:0]            sid_ff;
   logic [spms_pkg::DATA_W-1:0] val_ff;
   logic                        range_ff;
   logic [PTR_W-1:0]            top_rd_ff;
   logic                        top_hit_ff;

   // fetched slot data
   logic [PTR_W-1:0]            link_rd_ff;
   logic [PTR_W-1:0]            link_addr_ff;
   logic                        link_fresh_ff;
   logic [spms_pkg::DATA_W-1:0] value_rd_ff;

   logic [PTR_W-1:0]            top_ptr, link_addr, link_val;
   logic                        top_null, free_null, link_null;
   logic                        value_we, link_we, top_we;
   logic [PTR_W-1:0]            link_wa, link_wd, top_wd;
   logic [spms_pkg::DATA_W-1:0] rd_val;
   spms_pkg::status_type        st;
   logic                        empty_after;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_op;
         sid_ff     <= SID_W'(req_stack_id);
         val_ff     <= req_push_value;
         range_ff   <= (32'(req_stack_id) < 32'(STACK_COUNT));
         top_rd_ff  <= top_mem[SID_W'(req_stack_id)];
         top_hit_ff <= top_vld_ff[SID_W'(req_stack_id)];
      end
   end

   assign top_ptr   = top_hit_ff ? top_rd_ff : NULL_PTR;
   assign link_addr = (op_ff == spms_pkg::OP_PUSH) ? free_head_ff : top_ptr;

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         link_rd_ff    <= link_mem[link_addr[IDX_W-1:0]];
         value_rd_ff   <= value_mem[top_ptr[IDX_W-1:0]];
         link_addr_ff  <= link_addr;
         link_fresh_ff <= (link_addr >= fresh_ff);
      end
   end

   // unwritten link entries hold the reset chain i -> i+1
   assign link_val  = link_fresh_ff ? PTR_W'(link_addr_ff + 1'b1) : link_rd_ff;
   assign top_null  = (top_ptr >= NULL_PTR);
   assign free_null = (free_head_ff >= NULL_PTR);
   assign link_null = (link_val >= NULL_PTR);

   always_comb begin
      rd_val       = '0;
      st           = spms_pkg::ST_OK;
      empty_after  = 1'b1;
      free_head_in = free_head_ff;
      fresh_in     = fresh_ff;
      value_we     = 1'b0;
      link_we      = 1'b0;
      link_wa      = free_head_ff;
      link_wd      = top_ptr;
      top_we       = 1'b0;
      top_wd       = top_ptr;
      if (!range_ff) begin
         st = spms_pkg::ST_EMPTY;
      end else begin
         empty_after = top_null;
         case (op_ff)
            spms_pkg::OP_PUSH: begin
               if (free_null) begin
                  st = spms_pkg::ST_FULL;
               end else begin
                  value_we     = 1'b1;
                  link_we      = 1'b1;
                  link_wa      = free_head_ff;
                  link_wd      = top_null ? NULL_PTR : top_ptr;
                  top_we       = 1'b1;
                  top_wd       = free_head_ff;
                  free_head_in = link_null ? NULL_PTR : link_val;
                  if (free_head_ff == fresh_ff) begin
                     fresh_in = PTR_W'(fresh_ff + 1'b1);
                  end
                  empty_after  = 1'b0;
               end
            end
            spms_pkg::OP_POP: begin
               if (top_null) begin
                  st = spms_pkg::ST_EMPTY;
               end else begin
                  rd_val       = value_rd_ff;
                  top_we       = 1'b1;
                  top_wd       = link_null ? NULL_PTR : link_val;
                  link_we      = 1'b1;
                  link_wa      = top_ptr;
                  link_wd      = free_null ? NULL_PTR : free_head_ff;
                  free_head_in = top_ptr;
                  empty_after  = link_null;
               end
            end
            spms_pkg::OP_PEEK: begin
               if (top_null) begin
                  st = spms_pkg::ST_EMPTY;
               end else begin
                  rd_val = value_rd_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // memory writes and result register
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (value_we) begin
            value_mem[free_head_ff[IDX_W-1:0]] <= val_ff;
         end
         if (link_we) begin
            link_mem[link_wa[IDX_W-1:0]] <= link_wd;
         end
         if (top_we) begin
            top_mem[sid_ff] <= top_wd;
         end
         rsp_read_value  <= rd_val;
         rsp_status      <= st;
         rsp_stack_empty <= empty_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         fresh_ff     <= '0;
         top_vld_ff   <= '0;
      end else if (cmd.commit) begin
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
         if (top_we) begin
            top_vld_ff[sid_ff] <= 1'b1;
         end
      end
   end

endmodule

### rtl/shared_pool_multi_stack.sv
// Several LIFO stacks sharing one pool of POOL_SLOTS slots. Each request beat is a
// push, pop or peek on one of STACK_COUNT stacks and yields exactly one response
// beat: read_value (popped or peeked data, else 0), status (ok, stack empty, pool
// full) and stack_empty (addressed stack empty after the operation). A stack id
// of STACK_COUNT or more answers "empty" and changes nothing; op code 3 is a no-op.
// Each request runs accept, fetch, commit: the accept cycle reads the stack-top
// store, fetch reads the slot link and value stores (registered reads), commit
// updates the stores and loads the response register. The next request is
// accepted while a response beat still waits; commit then holds until that
// beat is taken. No clearing pass after reset: the top store uses per-stack
// valid bits and the untouched part of the free list is tracked by a fill count,
// so the block is ready as soon as reset is released.
module shared_pool_multi_stack #(
   parameter int POOL_SLOTS  = 16,
   parameter int STACK_COUNT = 3
) (
   input  logic        clock,
   input  logic        reset,
   spms_req_if.sink    req_chan,
   spms_rsp_if.source  rsp_chan
);

   spms_pkg::ctrl_cmd_type cmd;

   // sequencing: accept -> fetch -> commit
   spms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // stores, free list and response register
   spms_dpath #(
      .POOL_SLOTS  (POOL_SLOTS),
      .STACK_COUNT (STACK_COUNT)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_op          (req_chan.op),
      .req_stack_id    (req_chan.stack_id),
      .req_push_value  (req_chan.push_value),
      .rsp_read_value  (rsp_chan.read_value),
      .rsp_status      (rsp_chan.status),
      .rsp_stack_empty (rsp_chan.stack_empty)
   );

endmodule

### rtl/spms_checker.sv
module spms_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [spms_pkg::DATA_W-1:0]         rsp_read_value,
   input logic [spms_pkg::STATUS_W-1:0]       rsp_status,
   input logic                                rsp_stack_empty
);

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_status) && $stable(rsp_stack_empty))
      else $error("response beat changed while stalled");

   // one request in flight: busy right after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous still in flight");

   a_empty_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == spms_pkg::ST_EMPTY)
         |-> (rsp_read_value == '0) && rsp_stack_empty)
      else $error("empty status with data or non-empty stack");

   a_full_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == spms_pkg::ST_FULL) |-> (rsp_read_value == '0))
      else $error("full status with nonzero data");

endmodule

bind shared_pool_multi_stack spms_checker u_spms_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_read_value  (rsp_chan.read_value),
   .rsp_status      (rsp_chan.status),
   .rsp_stack_empty (rsp_chan.stack_empty)
);
